### design/quadratic_2d_map_step_macros.svh
// assertion macros for the quadratic map step block
// used by the controller; needs nothing else
`ifndef QUADRATIC_2D_MAP_STEP_MACROS_SVH
`define QUADRATIC_2D_MAP_STEP_MACROS_SVH

// same-cycle implication, checked out of reset
`define QMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define QMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/qms_pkg.sv
// types, constants and product schedule tables for the quadratic map step block
// no dependencies
`default_nettype none

package qms_pkg;

  localparam int FRAC_BITS = 60;
  localparam int DATA_W    = 64;
  localparam int ACC_W     = 2 * DATA_W;
  localparam int NUM_COEFS = 12;
  localparam int NUM_PRODS = 13;

  localparam logic [1:0] FUNC_STEP  = 2'd0;
  localparam logic [1:0] FUNC_SEED  = 2'd1;
  localparam logic [1:0] FUNC_COEF  = 2'd2;

  localparam logic [3:0] COEF_X0    = 4'd0;
  localparam logic [3:0] COEF_Y0    = 4'd6;
  localparam logic [3:0] PROD_FIRST_NX = 4'd3;
  localparam logic [3:0] PROD_FIRST_NY = 4'd8;
  localparam logic [3:0] PROD_LAST  = 4'(NUM_PRODS - 1);
  localparam logic [1:0] PART_LAST  = 2'd3;

  // product codes that feed the squared and cross terms
  localparam logic [3:0] PROD_X2 = 4'd0;
  localparam logic [3:0] PROD_Y2 = 4'd1;
  localparam logic [3:0] PROD_XY = 4'd2;

  // state operands
  localparam logic [2:0] VAR_X  = 3'd0;
  localparam logic [2:0] VAR_Y  = 3'd1;
  localparam logic [2:0] VAR_X2 = 3'd2;
  localparam logic [2:0] VAR_XY = 3'd3;
  localparam logic [2:0] VAR_Y2 = 3'd4;

  typedef struct packed {
    logic [1:0]               func;
    logic [3:0]               coef_index;
    logic signed [DATA_W-1:0] value_x;
    logic signed [DATA_W-1:0] value_y;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_out;
    logic signed [DATA_W-1:0] y_out;
  } out_item_t;

  typedef struct packed {
    logic       issue;
    logic [3:0] sel;
    logic [1:0] part;
    logic       init_c0;
    logic       init_c6;
    logic       load_seed;
    logic       write_coef;
    logic       commit;
    logic       out_load;
  } qms_cmd_t;

  // coefficient used by each product; squares and cross term take none
  function automatic logic [3:0] prod_coef(input logic [3:0] sel);
    logic [3:0] c;
    case (sel)
      4'd3:    c = 4'd1;
      4'd4:    c = 4'd4;
      4'd5:    c = 4'd2;
      4'd6:    c = 4'd3;
      4'd7:    c = 4'd5;
      4'd8:    c = 4'd7;
      4'd9:    c = 4'd10;
      4'd10:   c = 4'd8;
      4'd11:   c = 4'd9;
      4'd12:   c = 4'd11;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  // first operand for the squares and cross term
  function automatic logic [2:0] prod_var_a(input logic [3:0] sel);
    logic [2:0] v;
    case (sel)
      PROD_Y2: v = VAR_Y;
      default: v = VAR_X;
    endcase
    return v;
  endfunction

  // second operand: the state term each product multiplies
  function automatic logic [2:0] prod_var_b(input logic [3:0] sel);
    logic [2:0] v;
    case (sel)
      4'd0, 4'd3, 4'd8:  v = VAR_X;
      4'd1, 4'd2, 4'd4,
      4'd9:              v = VAR_Y;
      4'd5, 4'd10:       v = VAR_X2;
      4'd6, 4'd11:       v = VAR_XY;
      default:           v = VAR_Y2;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### design/qms_datapath.sv
// datapath: state registers, coefficient file, shared 33x33 multiplier and
// product accumulator; depends on qms_pkg
`default_nettype none

module qms_datapath
  import qms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire qms_cmd_t  cmd,
  input  wire in_item_t  in_data,
  output out_item_t      out_data
);

  logic signed [DATA_W-1:0] x_r, y_r, x2_r, y2_r, xy_r, nx_r, ny_r;
  logic signed [DATA_W-1:0] coef_mem [NUM_COEFS];
  out_item_t                out_r;

  logic [3:0]               coef_addr;
  logic signed [DATA_W-1:0] coef_rd, op_a, op_b, fx_res;
  logic signed [32:0]       mul_a, mul_b;
  logic signed [65:0]       prod_r;
  logic                     s1_vld_r, s2_vld_r, s2_last_r;
  logic [3:0]               s1_sel_r, s2_sel_r;
  logic [1:0]               s1_part_r;
  logic [ACC_W-1:0]         prod_ext, prod_sh, acc_r, acc_nxt;

  function automatic logic signed [DATA_W-1:0] pick_var(
    input logic [2:0]               v,
    input logic signed [DATA_W-1:0] x, y, x2, xy, y2
  );
    logic signed [DATA_W-1:0] r;
    case (v)
      VAR_X:   r = x;
      VAR_Y:   r = y;
      VAR_X2:  r = x2;
      VAR_XY:  r = xy;
      default: r = y2;
    endcase
    return r;
  endfunction

  always_comb begin
    if (cmd.init_c0) begin
      coef_addr = COEF_X0;
    end else if (cmd.init_c6) begin
      coef_addr = COEF_Y0;
    end else begin
      coef_addr = prod_coef(cmd.sel);
    end
  end

  assign coef_rd = coef_mem[coef_addr];

  // operand a is a state term for the first three products, a coefficient after
  assign op_a = (cmd.sel < PROD_FIRST_NX)
              ? pick_var(prod_var_a(cmd.sel), x_r, y_r, x2_r, xy_r, y2_r)
              : coef_rd;
  assign op_b = pick_var(prod_var_b(cmd.sel), x_r, y_r, x2_r, xy_r, y2_r);

  // part selects halves: lo*lo, lo*hi, hi*lo, hi*hi; low halves unsigned
  always_comb begin
    case (cmd.part)
      2'd0: begin
        mul_a = {1'b0, op_a[31:0]};
        mul_b = {1'b0, op_b[31:0]};
      end
      2'd1: begin
        mul_a = {1'b0, op_a[31:0]};
        mul_b = {op_b[63], op_b[63:32]};
      end
      2'd2: begin
        mul_a = {op_a[63], op_a[63:32]};
        mul_b = {1'b0, op_b[31:0]};
      end
      default: begin
        mul_a = {op_a[63], op_a[63:32]};
        mul_b = {op_b[63], op_b[63:32]};
      end
    endcase
  end

  assign prod_ext = {{(ACC_W-66){prod_r[65]}}, prod_r};

  always_comb begin
    case (s1_part_r)
      2'd0:    prod_sh = prod_ext;
      2'd3:    prod_sh = prod_ext << 64;
      default: prod_sh = prod_ext << 32;
    endcase
  end

  assign acc_nxt = (s1_part_r == 2'd0) ? prod_sh : acc_r + prod_sh;
  assign fx_res  = acc_r[FRAC_BITS +: DATA_W];

  always_ff @(posedge clk) begin
    // stage 1: partial product
    prod_r    <= mul_a * mul_b;
    s1_vld_r  <= cmd.issue;
    s1_sel_r  <= cmd.sel;
    s1_part_r <= cmd.part;

    // stage 2: accumulate partials
    if (s1_vld_r) begin
      acc_r <= acc_nxt;
    end
    s2_vld_r  <= s1_vld_r;
    s2_sel_r  <= s1_sel_r;
    s2_last_r <= (s1_part_r == PART_LAST);

    // stage 3: write back the finished fixed-point product
    if (s2_vld_r && s2_last_r) begin
      if (s2_sel_r == PROD_X2) begin
        x2_r <= fx_res;
      end else if (s2_sel_r == PROD_Y2) begin
        y2_r <= fx_res;
      end else if (s2_sel_r == PROD_XY) begin
        xy_r <= fx_res;
      end else if (s2_sel_r < PROD_FIRST_NY) begin
        nx_r <= nx_r + fx_res;
      end else begin
        ny_r <= ny_r + fx_res;
      end
    end

    if (cmd.init_c0) begin
      nx_r <= coef_rd;
    end
    if (cmd.init_c6) begin
      ny_r <= coef_rd;
    end

    if (cmd.write_coef) begin
      coef_mem[in_data.coef_index] <= in_data.value_x;
    end

    if (cmd.out_load) begin
      out_r.x_out <= x_r;
      out_r.y_out <= y_r;
    end
  end

  // x and y reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (cmd.load_seed) begin
      x_r <= in_data.value_x;
      y_r <= in_data.value_y;
    end else if (cmd.commit) begin
      x_r <= nx_r;
      y_r <= ny_r;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

### design/qms_controller.sv
// controller: item decode, product sequencing and result handshake
// depends on qms_pkg and quadratic_2d_map_step_macros.svh
`default_nettype none

`include "quadratic_2d_map_step_macros.svh"

module qms_controller
  import qms_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output qms_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INIT0  = 3'd1;
  localparam logic [2:0] ST_INIT1  = 3'd2;
  localparam logic [2:0] ST_ISSUE  = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_COMMIT = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [3:0] sel_r, sel_nxt;
  logic [1:0] part_r, part_nxt;
  logic       drain_r, drain_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free, last_issue;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign last_issue = (sel_r == PROD_LAST) && (part_r == PART_LAST);

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    part_nxt  = part_r;
    drain_nxt = drain_r;

    cmd            = '0;
    cmd.sel        = sel_r;
    cmd.part       = part_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_seed  = (in_data.func == FUNC_SEED);
          cmd.write_coef = (in_data.func == FUNC_COEF) &&
                           (in_data.coef_index < 4'(NUM_COEFS));
          state_nxt = (in_data.func == FUNC_STEP) ? ST_INIT0 : ST_DONE;
        end
      end
      ST_INIT0: begin
        cmd.init_c0 = 1'b1;
        state_nxt   = ST_INIT1;
      end
      ST_INIT1: begin
        cmd.init_c6 = 1'b1;
        sel_nxt     = '0;
        part_nxt    = '0;
        state_nxt   = ST_ISSUE;
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        part_nxt  = part_r + 2'd1;
        if (part_r == PART_LAST) begin
          sel_nxt = sel_r + 4'd1;
        end
        if (last_issue) begin
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last product to reach the sums
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= '0;
      part_r      <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      part_r      <= part_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `QMS_ASSERT_NEXT(a_step_starts, clk, rst_n, accept && (in_data.func == FUNC_STEP), state_r == ST_INIT0, "step item did not start the sequence")
  `QMS_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || !out_stall, "result loaded over one still waiting")
  `QMS_ASSERT_NEXT(a_last_issue_drains, clk, rst_n, (state_r == ST_ISSUE) && last_issue, (state_r == ST_DRAIN) && !cmd.issue, "product issue ran past the schedule")
  `QMS_ASSERT_NEXT(a_commit_then_done, clk, rst_n, cmd.commit, (state_r == ST_DONE) && !cmd.commit, "commit not followed by result")

endmodule

`default_nettype wire

### design/quadratic_2d_map_step.sv
// One iteration engine for a general two-dimensional quadratic map in signed
// 64-bit fixed point (60 fraction bits). Every item accepted yields exactly one
// transfer of the current x, y. A step item runs thirteen fixed-point products
// (x*x, y*y, x*y, then ten coefficient terms) through one shared 33x33-bit
// multiplier, four partial products each, then commits the new x, y and loads
// them into the output register; seed loads, coefficient writes and other codes
// load the output register directly. Either way the next item is taken once the
// result has been loaded. Items are taken one at a time; the result sits in an
// output register, so the next item is taken while the last one waits. x and y
// reset to zero.
// Coefficients must be written before a step reads them.
`default_nettype none

module quadratic_2d_map_step
  import qms_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  qms_cmd_t cmd;

  qms_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  qms_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### tb/quadratic_2d_map_step_test.sv
// self-checking testbench for the quadratic map step block: directed corner items,
// then random orbits and noise, with random idling on both channels
// depends on qms_pkg and quadratic_2d_map_step
module quadratic_2d_map_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qms_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int IDLE_MAX     = 5;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 830;

  localparam logic signed [63:0] MAX_V   = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] MIN_V   = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] FX_ONE  = 64'sd1 <<< FRAC_BITS;
  // classic chaotic parameters a = 1.4, b = 0.3 in 60-bit fraction format
  localparam logic signed [63:0] HENON_A = 64'sd1614090106449585766;
  localparam logic signed [63:0] HENON_B = 64'sd345876451382054093;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  // map state and coefficients as the block should hold them
  logic signed [63:0] map_x = '0;
  logic signed [63:0] map_y = '0;
  logic signed [63:0] coef_bank [NUM_COEFS];
  out_item_t          pending_xy [$];

  int items_sent   = 0;
  int useful_items = 0;
  int step_count   = 0;
  int results_seen = 0;
  int fault_count  = 0;
  int stall_left   = 0;
  int idle_cycles  = 0;
  bit no_idle      = 1'b0;

  quadratic_2d_map_step DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // roughly within +-1.0
  function automatic logic signed [63:0] rand_small();
    return rand64() >>> 3;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] code, input logic [3:0] idx,
                                         input logic signed [63:0] vx,
                                         input logic signed [63:0] vy);
    in_item_t it;
    it.func       = code;
    it.coef_index = idx;
    it.value_x    = vx;
    it.value_y    = vy;
    return it;
  endfunction

  // full-width signed product, arithmetic shift by the fraction bits, low 64 bits kept
  function automatic logic signed [63:0] fx_product(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
    logic signed [127:0] wa, wb, full;
    wa   = a;
    wb   = b;
    full = wa * wb;
    return full[FRAC_BITS+63:FRAC_BITS];
  endfunction

  function automatic logic signed [63:0] quad_term(input int base,
                                                   input logic signed [63:0] x,
                                                   input logic signed [63:0] y,
                                                   input logic signed [63:0] x2,
                                                   input logic signed [63:0] xy,
                                                   input logic signed [63:0] y2);
    return coef_bank[base] + fx_product(coef_bank[base+1], x)
         + fx_product(coef_bank[base+2], x2) + fx_product(coef_bank[base+3], xy)
         + fx_product(coef_bank[base+4], y) + fx_product(coef_bank[base+5], y2);
  endfunction

  function automatic out_item_t next_xy(input in_item_t it);
    logic signed [63:0] x2, xy, y2, nx, ny;
    out_item_t r;
    case (it.func)
      FUNC_STEP: begin
        x2 = fx_product(map_x, map_x);
        y2 = fx_product(map_y, map_y);
        xy = fx_product(map_x, map_y);
        nx = quad_term(COEF_X0, map_x, map_y, x2, xy, y2);
        ny = quad_term(COEF_Y0, map_x, map_y, x2, xy, y2);
        map_x = nx;
        map_y = ny;
        step_count++;
      end
      FUNC_SEED: begin
        map_x = it.value_x;
        map_y = it.value_y;
      end
      FUNC_COEF: begin
        if (it.coef_index < NUM_COEFS) coef_bank[it.coef_index] = it.value_x;
      end
      default: ;
    endcase
    r.x_out = map_x;
    r.y_out = map_y;
    return r;
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_xy.push_back(next_xy(item));
    items_sent++;
    if (!(item.func == FUNC_SPARE || (item.func == FUNC_COEF && item.coef_index >= NUM_COEFS)))
      useful_items++;
  endtask

  // spare code and out-of-range indexes leave everything as it is
  task automatic test_unused_codes();
    send_item(make_item(FUNC_SPARE, 4'hF, -64'sd1, -64'sd1));
    send_item(make_item(FUNC_COEF, 4'd12, MAX_V, MIN_V));
    send_item(make_item(FUNC_COEF, 4'd15, MIN_V, -64'sd1));
  endtask

  task automatic test_seed_extremes();
    send_item(make_item(FUNC_SEED, 4'd0, MAX_V, MIN_V));
    send_item(make_item(FUNC_SEED, 4'hF, MIN_V, MAX_V));
    send_item(make_item(FUNC_SEED, 4'd5, '0, -64'sd1));
  endtask

  task automatic test_coefficient_extremes();
    logic signed [63:0] corner [NUM_COEFS];
    corner = '{MAX_V, MIN_V, -64'sd1, 64'sd1, FX_ONE, -FX_ONE,
               MIN_V, MAX_V, '0, 64'sd1, -64'sd1, MAX_V};
    for (int i = 0; i < NUM_COEFS; i++)
      send_item(make_item(FUNC_COEF, 4'(i), corner[i], rand64()));
    // steps from the state left before and from extreme seeds
    send_item(make_item(FUNC_STEP, 4'hF, -64'sd1, -64'sd1));
    send_item(make_item(FUNC_SEED, 4'd0, MAX_V, MIN_V));
    send_item(make_item(FUNC_STEP, 4'd0, '0, '0));
    send_item(make_item(FUNC_SEED, 4'd0, MIN_V, MAX_V));
    send_item(make_item(FUNC_STEP, 4'd3, MAX_V, MIN_V));
    send_item(make_item(FUNC_STEP, 4'd9, rand64(), rand64()));
  endtask

  task automatic load_coefficients(input int scheme);
    logic signed [63:0] c;
    for (int i = 0; i < NUM_COEFS; i++) begin
      case (scheme)
        0: begin
          case (i)
            0, 4:    c = FX_ONE;
            2:       c = -HENON_A;
            7:       c = HENON_B;
            default: c = '0;
          endcase
        end
        1:       c = rand_small();
        default: c = rand64();
      endcase
      send_item(make_item(FUNC_COEF, 4'(i), c, rand64()));
    end
  endtask

  // mostly orbits from a seed, with some loose items mixed in
  task automatic test_random_orbits();
    int goal;
    int pick;
    goal = useful_items + RANDOM_ITEMS;
    while (useful_items < goal) begin
      no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        if ($urandom_range(0, 2) == 0) begin
          pick = $urandom_range(0, 3);
          load_coefficients(pick < 2 ? 0 : pick - 1);
        end
        send_item(make_item(FUNC_SEED, 4'($urandom), rand_small(), rand_small()));
        repeat ($urandom_range(5, 25))
          send_item(make_item(FUNC_STEP, 4'($urandom), rand64(), rand64()));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(make_item(2'($urandom), 4'($urandom), rand64(), rand64()));
      end
    end
    no_idle = 1'b0;
  endtask

  // result side back-pressure, redrawn after each transfer
  always @(posedge clk) begin
    if (out_valid && !out_stall) stall_left = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    else if (stall_left != 0) stall_left--;
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_xy.size() == 0) begin
        fault_count++;
        $error("unexpected result: x_out %0d, y_out %0d", out_data.x_out, out_data.y_out);
      end else begin
        want = pending_xy.pop_front();
        if (out_data.x_out !== want.x_out) begin
          fault_count++;
          $error("x_out: expected %0d, got %0d", want.x_out, out_data.x_out);
        end
        if (out_data.y_out !== want.y_out) begin
          fault_count++;
          $error("y_out: expected %0d, got %0d", want.y_out, out_data.y_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_unused_codes();
    test_seed_extremes();
    test_coefficient_extremes();
    test_random_orbits();
    in_valid <= 1'b0;
    wait (pending_xy.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d items (%0d map steps), compared %0d results", items_sent,
             step_count, results_seen);
    $display("covered corner seeds and coefficients, spare codes and random orbits");
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
